// ===== hw/rtl/tlbfl_pkg.sv =====
// Package for the FIFO/LRU TLB: sizes, codes, sequencer states and compare result type.
package tlbfl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int PAGE_BITS   = 20;
  localparam int FRAME_BITS  = 20;
  localparam int STAMP_BITS  = 32;

  localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_FRAME_W = 20;
  localparam int SLOT_W      = 4;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'b1;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic match;  // valid entry holds the key page
    logic free;   // entry is not valid
    logic lower;  // stamp beats the best so far (or first entry)
  } cmp_t;

endpackage

// ===== hw/rtl/tlb_fifo_lru_replacement.sv =====
// Top level of the fully associative TLB with FIFO or LRU replacement.
//
// Fully associative TLB held in registers. A small sequencer walks the slots
// in index order, one slot per clock, through a single shared compare unit
// that does the tag match, the free-slot check and the stamp compare for LRU.
// The scan stops at a hit, at a free slot for an insert, or at the last slot
// in use; a hit or an insert then passes through an update state, a lookup
// miss goes straight to the emit state. The block takes no new item until
// the result has moved into the output register. The output register parts
// the two sides, so a new item is accepted while a finished result still
// waits on out_stall. Configuration (cfg_index 0: entries_in_use, 1:
// replacement_mode) must be written by the user only while the block is
// idle; the block itself does not enforce this. entries_in_use of 0 acts
// as 1, above the built depth as the depth. No clearing pass is needed:
// only the valid bits reset.
module tlb_fifo_lru_replacement (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [tlbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlbfl_pkg::CFG_W-1:0]       cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic [tlbfl_pkg::PAGE_BITS-1:0]   page,
  input  logic [tlbfl_pkg::FRAME_BITS-1:0]  frame,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [tlbfl_pkg::OUT_FRAME_W-1:0] frame_out,
  output logic [tlbfl_pkg::SLOT_W-1:0]      slot
);
  import tlbfl_pkg::*;

  // configuration
  logic [CFG_W-1:0] entries_in_use;
  logic             replacement_mode;

  // entry storage
  logic                  slot_valid [MAX_ENTRIES];
  logic [PAGE_BITS-1:0]  slot_page  [MAX_ENTRIES];
  logic [FRAME_BITS-1:0] slot_frame [MAX_ENTRIES];
  logic [STAMP_BITS-1:0] slot_stamp [MAX_ENTRIES];
  logic [STAMP_BITS-1:0] use_counter;
  logic [IDX_BITS-1:0]   fifo_pointer;

  // sequencer
  state_t state, state_next;
  logic [IDX_BITS-1:0]   idx;
  logic [IDX_BITS-1:0]   tgt;
  logic [IDX_BITS-1:0]   best_idx;
  logic [STAMP_BITS-1:0] best_stamp;
  logic                  cmd_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic                  res_hit;
  logic [FRAME_BITS-1:0] res_frame;

  logic [IDX_BITS-1:0]   last_idx;
  logic [IDX_BITS-1:0]   fifo_v;
  logic [IDX_BITS-1:0]   victim;
  logic [STAMP_BITS-1:0] stamp_new;
  cmp_t                  cmp;
  logic                  hit_now;
  logic                  free_now;
  logic                  at_end;
  logic                  in_xfer;
  logic                  out_load;

  // highest slot index taking part
  always_comb begin
    if (entries_in_use == '0) begin
      last_idx = '0;
    end else if (32'(entries_in_use) > 32'(MAX_ENTRIES)) begin
      last_idx = IDX_BITS'(MAX_ENTRIES - 1);
    end else begin
      last_idx = IDX_BITS'(entries_in_use - CFG_W'(1));
    end
  end

  tlbfl_cmp u_cmp (
    .key_page    (page_q),
    .entry_valid (slot_valid[idx]),
    .entry_page  (slot_page[idx]),
    .entry_stamp (slot_stamp[idx]),
    .best_stamp  (best_stamp),
    .first       (idx == '0),
    .res         (cmp)
  );

  assign hit_now  = (cmd_q == CMD_LOOKUP) && cmp.match;
  assign free_now = (cmd_q == CMD_INSERT) && cmp.free;
  assign at_end   = (idx == last_idx);

  // victim choice, only used once the whole range is found full
  assign fifo_v = (fifo_pointer <= last_idx) ? fifo_pointer : '0;
  always_comb begin
    if (replacement_mode == MODE_FIFO) begin
      victim = fifo_v;
    end else begin
      victim = cmp.lower ? idx : best_idx;
    end
  end

  // saturating use counter
  assign stamp_new = (use_counter == '1) ? use_counter : use_counter + STAMP_BITS'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit_now || free_now) begin
          state_next = ST_UPDATE;
        end else if (at_end) begin
          state_next = (cmd_q == CMD_LOOKUP) ? ST_EMIT : ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   ;
      ST_UPDATE: ;
      ST_EMIT:   out_load = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  assign in_xfer = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use   <= ENTRIES_RESET;
      replacement_mode <= MODE_FIFO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRIES: entries_in_use   <= cfg_data;
        REG_MODE:    replacement_mode <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      use_counter  <= '0;
      fifo_pointer <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) slot_valid[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN && at_end && !hit_now && !free_now &&
          cmd_q == CMD_INSERT && replacement_mode == MODE_FIFO) begin
        fifo_pointer <= (fifo_v == last_idx) ? '0 : fifo_v + IDX_BITS'(1);
      end
      if (state == ST_UPDATE) begin
        use_counter <= stamp_new;
        if (cmd_q == CMD_INSERT) slot_valid[tgt] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q     <= cmd;
      page_q    <= page;
      frame_q   <= frame;
      idx       <= '0;
      tgt       <= '0;
      res_hit   <= 1'b0;
      res_frame <= '0;
    end
    if (state == ST_SCAN) begin
      if (cmp.lower) begin
        best_stamp <= slot_stamp[idx];
        best_idx   <= idx;
      end
      if (hit_now) begin
        tgt       <= idx;
        res_hit   <= 1'b1;
        res_frame <= slot_frame[idx];
      end else if (free_now) begin
        tgt <= idx;
      end else if (at_end) begin
        if (cmd_q == CMD_INSERT) tgt <= victim;
      end else begin
        idx <= idx + IDX_BITS'(1);
      end
    end
    if (state == ST_UPDATE) begin
      slot_stamp[tgt] <= stamp_new;
      if (cmd_q == CMD_INSERT) begin
        slot_page[tgt]  <= page_q;
        slot_frame[tgt] <= frame_q;
      end
    end
    if (out_load) begin
      hit       <= res_hit;
      frame_out <= OUT_FRAME_W'(res_frame);
      // a miss leaves tgt at zero
      slot      <= SLOT_W'(tgt);
    end
  end

  // checks
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx <= last_idx)
    else $error("scan index beyond slots in use");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == ST_IDLE)
    else $error("result not presented after emit");

  a_counter_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> use_counter >= $past(use_counter))
    else $error("use counter went backward");

  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && cmd_q == CMD_INSERT) |=> slot_valid[$past(tgt)])
    else $error("inserted slot not marked valid");

  a_hit_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && res_hit) |-> cmd_q == CMD_LOOKUP)
    else $error("hit flagged on insert");

endmodule

// ===== hw/rtl/tlbfl_cmp.sv =====
// Shared per-slot compare unit: tag match, free check and stamp compare.
module tlbfl_cmp (
  input  logic [tlbfl_pkg::PAGE_BITS-1:0]  key_page,
  input  logic                             entry_valid,
  input  logic [tlbfl_pkg::PAGE_BITS-1:0]  entry_page,
  input  logic [tlbfl_pkg::STAMP_BITS-1:0] entry_stamp,
  input  logic [tlbfl_pkg::STAMP_BITS-1:0] best_stamp,
  input  logic                             first,
  output tlbfl_pkg::cmp_t                  res
);
  import tlbfl_pkg::*;

  always_comb begin
    res.match = entry_valid && (entry_page == key_page);
    res.free  = !entry_valid;
    // strict less keeps the lowest index on ties
    res.lower = first || (entry_stamp < best_stamp);
  end

endmodule
